// ===== rtl/core/fraction_add_mul_reduce_assert.svh =====
// assertion macros shared by the fraction add/multiply/reduce rtl
`ifndef FRACTION_ADD_MUL_REDUCE_ASSERT_SVH
`define FRACTION_ADD_MUL_REDUCE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FAMR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FAMR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/famr_pkg.sv =====
// shared types and constants for the fraction add/multiply/reduce block
package famr_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int NUM_OUT_W     = 33;
  localparam int DEN_OUT_W     = 32;
  localparam int OUT_DW        = ((NUM_OUT_W + DEN_OUT_W + 7) / 8) * 8;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_MUL = 1'b1;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } famr_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_GCD_CHK,
    S_GCD_RUN,
    S_DIVN,
    S_DIVD,
    S_OUT
  } famr_state_t;

endpackage

// ===== rtl/core/famr_mul.sv =====
// bit-serial shift-add unsigned multiplier, one multiplier bit per cycle
module famr_mul #(
  parameter int W = famr_pkg::OPERAND_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [W-1:0]        a,
  input  logic [W-1:0]        b,
  output logic [2*W-1:0]      prod,
  output famr_pkg::famr_stat_t stat
);
  import famr_pkg::*;

  localparam int CW = $clog2(W);

  logic [2*W-1:0] p;
  logic [W-1:0]   a_r;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic           done;
  logic [W:0]     sum;

  // add multiplicand into the upper half when the current multiplier bit is set
  assign sum = {1'b0, p[2*W-1:W]} + (p[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p   <= {{W{1'b0}}, b};
      a_r <= a;
    end else if (busy) begin
      p <= {sum, p[W-1:1]};
    end
  end

  assign prod      = p;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/core/famr_div.sv =====
// restoring divider, one quotient bit per cycle, gives quotient and remainder
module famr_div #(
  parameter int WD = 2 * famr_pkg::OPERAND_WIDTH + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WD-1:0]        dividend,
  input  logic [WD-1:0]        divisor,
  output logic [WD-1:0]        quot,
  output logic [WD-1:0]        rem,
  output famr_pkg::famr_stat_t stat
);
  import famr_pkg::*;

  localparam int CW = $clog2(WD);

  logic [WD-1:0] quo;
  logic [WD-1:0] rm;
  logic [WD-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [WD:0]   trial;
  logic [WD+1:0] diff;
  logic          borrow;

  assign trial  = {rm, quo[WD-1]};
  assign diff   = {1'b0, trial} - {2'b00, dvs};
  assign borrow = diff[WD+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(WD - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rm  <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[WD-2:0], ~borrow};
      rm  <= borrow ? trial[WD-1:0] : diff[WD-1:0];
    end
  end

  assign quot      = quo;
  assign rem       = rm;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/core/fraction_add_mul_reduce.sv =====
// top level: adds or multiplies two signed fractions and reduces the result by euclid
//
// usage
//   input channel s_axis: one item per operation, tuser is the command
//   (0 add, 1 multiply), tdata carries num_a, den_a, num_b, den_b
//   output channel m_axis: one item per input item, tdata carries the
//   reduced numerator and denominator, tuser flags a 0/0 raw result
// throughput
//   one item at a time; s_axis_tready is high only while the block is free
//   products are formed on three bit-serial multipliers that run in parallel;
//   each euclid remainder step and both final divisions run on the one shared
//   restoring divider, so the time to a result depends on the data-dependent
//   number of euclid steps; the next item is taken only once the previous
//   result has moved into the output register
// reset
//   synchronous rst returns the sequencer to idle and empties the output register
// stalls
//   a finished item waits in the output register; the next input item is
//   taken meanwhile and its result is held back until the register is free
`include "fraction_add_mul_reduce_assert.svh"

module fraction_add_mul_reduce #(
  parameter  int OPERAND_WIDTH = famr_pkg::OPERAND_WIDTH,
  localparam int IN_DW         = ((4 * OPERAND_WIDTH + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // num_a, den_a, num_b, den_b from bit 0 up, zero padded to whole bytes
  input  logic [IN_DW-1:0]            s_axis_tdata,
  // cmd
  input  logic                        s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // num_out, den_out from bit 0 up, zero padded to whole bytes
  output logic [famr_pkg::OUT_DW-1:0] m_axis_tdata,
  // div_zero
  output logic                        m_axis_tuser
);
  import famr_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int NW = 2 * W + 1;   // raw numerator magnitude can reach 2^(2W-1)
  localparam int XN = (NW > NUM_OUT_W) ? NW : NUM_OUT_W;
  localparam int XD = (NW > DEN_OUT_W) ? NW : DEN_OUT_W;
  localparam int PADW = OUT_DW - NUM_OUT_W - DEN_OUT_W;

  famr_state_t state, state_next;

  // operand fields and their magnitudes
  logic [W-1:0] na, da, nb, db;
  logic [W-1:0] na_mag, da_mag, nb_mag, db_mag;

  assign na = s_axis_tdata[0*W +: W];
  assign da = s_axis_tdata[1*W +: W];
  assign nb = s_axis_tdata[2*W +: W];
  assign db = s_axis_tdata[3*W +: W];

  assign na_mag = na[W-1] ? (~na + 1'b1) : na;
  assign da_mag = da[W-1] ? (~da + 1'b1) : da;
  assign nb_mag = nb[W-1] ? (~nb + 1'b1) : nb;
  assign db_mag = db[W-1] ? (~db + 1'b1) : db;

  // product signs, taken at accept
  logic cmd_q, s1_neg, s2_neg, s3_neg;

  // serial multipliers: first product, cross product, denominator product
  logic [PW-1:0] prod1, prod2, prod3;
  famr_stat_t    m1_stat, m2_stat, m3_stat;
  logic          mul_start, mul_done, mul_busy;

  famr_mul #(.W(W)) u_mul1 (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (na_mag),
    .b    ((s_axis_tuser == CMD_MUL) ? nb_mag : db_mag),
    .prod (prod1),
    .stat (m1_stat)
  );

  famr_mul #(.W(W)) u_mul2 (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (nb_mag),
    .b    (da_mag),
    .prod (prod2),
    .stat (m2_stat)
  );

  famr_mul #(.W(W)) u_mul3 (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (da_mag),
    .b    (db_mag),
    .prod (prod3),
    .stat (m3_stat)
  );

  assign mul_done = m1_stat.done & m2_stat.done & m3_stat.done;
  assign mul_busy = m1_stat.busy & m2_stat.busy & m3_stat.busy;

  // raw pair and euclid operands, sign and magnitude
  logic [NW-1:0] n_mag, d_mag, a_mag, b_mag;
  logic          n_neg, d_neg, a_neg, b_neg;

  // combining the products
  logic [NW-1:0] e1, e2, e3, add_mag;
  logic [NW:0]   d12, d21;
  logic [NW-1:0] sum12;
  logic          p1_neg, p2_neg, add_neg;
  logic [NW-1:0] raw_n_mag;
  logic          raw_n_neg;

  assign e1 = NW'(prod1);
  assign e2 = NW'(prod2);
  assign e3 = NW'(prod3);
  assign p1_neg = s1_neg && (e1 != '0);
  assign p2_neg = s2_neg && (e2 != '0);
  assign sum12  = e1 + e2;
  assign d12    = {1'b0, e1} - {1'b0, e2};
  assign d21    = {1'b0, e2} - {1'b0, e1};

  always_comb begin
    if (p1_neg == p2_neg) begin
      add_mag = sum12;
      add_neg = p1_neg;
    end else if (!d12[NW]) begin
      add_mag = d12[NW-1:0];
      add_neg = p1_neg;
    end else begin
      add_mag = d21[NW-1:0];
      add_neg = p2_neg;
    end
    if (cmd_q == CMD_MUL) begin
      raw_n_mag = e1;
      raw_n_neg = p1_neg;
    end else begin
      raw_n_mag = add_mag;
      raw_n_neg = add_neg && (add_mag != '0);
    end
  end

  // shared divider
  logic [NW-1:0] div_dividend, div_divisor, div_quot, div_rem;
  famr_stat_t    div_stat;
  logic          div_start;

  famr_div #(.WD(NW)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .quot    (div_quot),
    .rem     (div_rem),
    .stat    (div_stat)
  );

  // reduced magnitudes and output register
  logic [NW-1:0]        qn, qd;
  logic                 dz;
  logic                 out_free;
  logic [NUM_OUT_W-1:0] num_r;
  logic [DEN_OUT_W-1:0] den_r;
  logic                 dz_r;
  logic                 out_valid;
  logic [XN-1:0]        qn_x, num_res;
  logic [XD-1:0]        qd_x, den_res;
  logic                 num_neg, den_neg;

  assign out_free = !out_valid || m_axis_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (s_axis_tvalid) state_next = S_MUL;
      S_MUL:     if (mul_done) state_next = S_SUM;
      S_SUM:     state_next = S_GCD_CHK;
      S_GCD_CHK: begin
        if (b_mag != '0) state_next = S_GCD_RUN;
        else if (a_mag != '0) state_next = S_DIVN;
        else state_next = S_OUT;
      end
      S_GCD_RUN: if (div_stat.done) state_next = S_GCD_CHK;
      S_DIVN:    if (div_stat.done) state_next = S_DIVD;
      S_DIVD:    if (div_stat.done) state_next = S_OUT;
      S_OUT:     if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    div_dividend  = a_mag;
    div_divisor   = b_mag;
    case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        mul_start     = s_axis_tvalid;
      end
      S_GCD_CHK: begin
        // remainder step while b is nonzero, otherwise a is the gcd: n / g
        if (b_mag != '0) begin
          div_start = 1'b1;
        end else begin
          div_start    = (a_mag != '0);
          div_dividend = n_mag;
          div_divisor  = a_mag;
        end
      end
      S_DIVN: begin
        div_start    = div_stat.done;
        div_dividend = d_mag;
        div_divisor  = a_mag;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // final signs follow truncating division by a signed gcd
  assign num_neg = (qn != '0) && (n_neg != a_neg);
  assign den_neg = (qd != '0) && (d_neg != a_neg);
  assign qn_x    = XN'(qn);
  assign qd_x    = XD'(qd);
  assign num_res = num_neg ? (~qn_x + 1'b1) : qn_x;
  assign den_res = den_neg ? (~qd_x + 1'b1) : qd_x;

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_q  <= s_axis_tuser;
          s1_neg <= na[W-1] ^ ((s_axis_tuser == CMD_MUL) ? nb[W-1] : db[W-1]);
          s2_neg <= nb[W-1] ^ da[W-1];
          s3_neg <= da[W-1] ^ db[W-1];
        end
      end
      S_SUM: begin
        n_mag <= raw_n_mag;
        n_neg <= raw_n_neg;
        d_mag <= e3;
        d_neg <= s3_neg && (e3 != '0);
        a_mag <= raw_n_mag;
        a_neg <= raw_n_neg;
        b_mag <= e3;
        b_neg <= s3_neg && (e3 != '0);
        dz    <= 1'b0;
      end
      S_GCD_CHK: begin
        // both raw values zero: no gcd, flag it
        if (b_mag == '0 && a_mag == '0) begin
          qn <= '0;
          qd <= '0;
          dz <= 1'b1;
        end
      end
      S_GCD_RUN: begin
        if (div_stat.done) begin
          a_mag <= b_mag;
          a_neg <= b_neg;
          b_mag <= div_rem;
          b_neg <= a_neg && (div_rem != '0);
        end
      end
      S_DIVN: if (div_stat.done) qn <= div_quot;
      S_DIVD: if (div_stat.done) qd <= div_quot;
      S_OUT: begin
        if (out_free) begin
          num_r <= num_res[NUM_OUT_W-1:0];
          den_r <= den_res[DEN_OUT_W-1:0];
          dz_r  <= dz;
        end
      end
      default: begin
        dz <= dz;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{PADW{1'b0}}, den_r, num_r};
  assign m_axis_tuser  = dz_r;

  `FAMR_ASSERT_NEXT(a_mul_runs, mul_start, mul_busy, "multipliers did not start")
  `FAMR_ASSERT_NOW(a_div_free, div_start, !div_stat.busy, "divider restarted while busy")
  `FAMR_ASSERT_NOW(a_gcd_divisor, state == S_GCD_RUN, b_mag != '0, "euclid step with zero divisor")
  `FAMR_ASSERT_NOW(a_dz_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "0/0 with data")

endmodule

// ===== sim/tb_fraction_add_mul_reduce.sv =====
// self-checking testbench for the fraction add/multiply/reduce block, predicted item by item
module tb_fraction_add_mul_reduce;
  timeunit 1ns;
  timeprecision 1ps;

  import famr_pkg::*;

  localparam int IN_DW = ((4 * OPERAND_WIDTH + 7) / 8) * 8;

  typedef logic signed [OPERAND_WIDTH-1:0] operand_t;

  // most negative and most positive operand
  localparam operand_t OP_MIN = {1'b1, {(OPERAND_WIDTH-1){1'b0}}};
  localparam operand_t OP_MAX = {1'b0, {(OPERAND_WIDTH-1){1'b1}}};

  // sign and magnitude, wide enough for every raw value
  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } magnitude_t;

  // one reduced result as it should leave the block
  typedef struct packed {
    logic [NUM_OUT_W-1:0] num;
    logic [DEN_OUT_W-1:0] den;
    logic                 div_zero;
  } fraction_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DW-1:0]     s_axis_tdata = '0;
  logic                 s_axis_tuser = CMD_ADD;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_DW-1:0]    m_axis_tdata;
  logic                 m_axis_tuser;

  fraction_t reduced_pending[$];
  int        fail_count = 0;
  // random idling on both sides, switched off for the last stretch
  bit        idle_en = 1'b1;

  fraction_add_mul_reduce #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic magnitude_t to_magnitude(operand_t v);
    magnitude_t m;
    longint     s;
    s = longint'(v);
    m.neg = v[OPERAND_WIDTH-1];
    m.mag = m.neg ? 64'(-s) : 64'(s);
    return m;
  endfunction

  function automatic magnitude_t mag_product(magnitude_t a, magnitude_t b);
    magnitude_t r;
    r.mag = a.mag * b.mag;
    r.neg = (r.mag != 0) && (a.neg != b.neg);
    return r;
  endfunction

  // truncating quotient, sign cleared on a zero result
  function automatic magnitude_t mag_quotient(magnitude_t a, magnitude_t g);
    magnitude_t r;
    r.mag = a.mag / g.mag;
    r.neg = (r.mag != 0) && (a.neg != g.neg);
    return r;
  endfunction

  function automatic logic [63:0] to_twos(magnitude_t v);
    return v.neg ? -v.mag : v.mag;
  endfunction

  // combines the two fractions and reduces by signed euclid, remainder takes the
  // sign of the dividend so signs may end up on the denominator
  function automatic fraction_t reduce_fraction(logic cmd, operand_t na, operand_t da,
                                                operand_t nb, operand_t db);
    magnitude_t m_na, m_da, m_nb, m_db;
    magnitude_t p, q, raw_n, raw_d, x, y, t;
    fraction_t  r;
    m_na = to_magnitude(na);
    m_da = to_magnitude(da);
    m_nb = to_magnitude(nb);
    m_db = to_magnitude(db);
    if (cmd == CMD_MUL) begin
      raw_n = mag_product(m_na, m_nb);
    end else begin
      p = mag_product(m_na, m_db);
      q = mag_product(m_nb, m_da);
      if (p.neg == q.neg) begin
        raw_n = '{neg: p.neg, mag: p.mag + q.mag};
      end else if (p.mag >= q.mag) begin
        raw_n = '{neg: p.neg, mag: p.mag - q.mag};
      end else begin
        raw_n = '{neg: q.neg, mag: q.mag - p.mag};
      end
      if (raw_n.mag == 0) raw_n.neg = 1'b0;
    end
    raw_d = mag_product(m_da, m_db);
    x = raw_n;
    y = raw_d;
    while (y.mag != 0) begin
      t.mag = x.mag % y.mag;
      t.neg = x.neg && (t.mag != 0);
      x = y;
      y = t;
    end
    if (x.mag == 0) begin
      // 0/0 raw: flagged instead of dividing by zero
      r.num      = '0;
      r.den      = '0;
      r.div_zero = 1'b1;
    end else begin
      r.num      = NUM_OUT_W'(to_twos(mag_quotient(raw_n, x)));
      r.den      = DEN_OUT_W'(to_twos(mag_quotient(raw_d, x)));
      r.div_zero = 1'b0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // mixes full-range values with small ones so that real reductions happen
  function automatic operand_t pick_operand();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return operand_t'($urandom());
      4, 5:       return operand_t'(int'($urandom_range(0, 24)) - 12);
      6: begin
        case ($urandom_range(0, 4))
          0:       return OP_MIN;
          1:       return OP_MAX;
          2:       return operand_t'(-1);
          3:       return operand_t'(1);
          default: return operand_t'(0);
        endcase
      end
      7:       return operand_t'((int'($urandom_range(0, 14)) - 7) <<< $urandom_range(0, 11));
      default: return operand_t'(int'($urandom_range(0, 600)) - 300);
    endcase
  endfunction

  // offers one item and waits for the handshake; valid stays high on return so
  // a following item goes out back to back
  task automatic send_operands(input logic cmd, input operand_t na, input operand_t da,
                               input operand_t nb, input operand_t db);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DW'({db, nb, da, na});
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    reduced_pending.push_back(reduce_fraction(cmd, na, da, nb, db));
  endtask

  task automatic send_random(input logic cmd);
    send_operands(cmd, pick_operand(), pick_operand(), pick_operand(), pick_operand());
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_operand_extremes();
    send_operands(CMD_ADD, OP_MIN, OP_MIN, OP_MIN, OP_MIN);
    send_operands(CMD_MUL, OP_MIN, OP_MIN, OP_MIN, OP_MIN);
    send_operands(CMD_ADD, OP_MAX, OP_MAX, OP_MAX, OP_MAX);
    send_operands(CMD_MUL, OP_MAX, OP_MAX, OP_MAX, OP_MAX);
    send_operands(CMD_ADD, OP_MAX, OP_MIN, OP_MIN, OP_MAX);
    send_operands(CMD_MUL, OP_MIN, OP_MAX, OP_MIN, 1);
    send_operands(CMD_ADD, 1, OP_MAX, 1, OP_MIN);
    send_operands(CMD_ADD, OP_MIN, 1, OP_MIN, -1);
  endtask

  task automatic test_special_cases();
    // both raw values zero
    send_operands(CMD_ADD, 0, 0, 0, 0);
    send_operands(CMD_ADD, 7, 0, -3, 0);
    send_operands(CMD_MUL, 0, 0, 3, 4);
    // zero numerator, nonzero denominator
    send_operands(CMD_ADD, 0, 5, 0, -7);
    send_operands(CMD_MUL, 0, 3, 9, 4);
    send_operands(CMD_ADD, 3, 4, -3, 4);
    // zero denominator, nonzero numerator
    send_operands(CMD_MUL, 5, 0, 7, 0);
    send_operands(CMD_ADD, 3, 0, 4, 5);
    send_operands(CMD_MUL, -3, 0, 4, 5);
    // signs landing on either side after reduction
    send_operands(CMD_MUL, 6, -4, 1, 1);
    send_operands(CMD_ADD, 1, -2, 1, -2);
    send_operands(CMD_MUL, -1, 2, 3, -4);
    // consecutive fibonacci values give the longest euclid chain
    send_operands(CMD_MUL, 28657, 17711, 1, 1);
    send_operands(CMD_ADD, 28657, 17711, -17711, 10946);
  endtask

  task automatic test_random_add();
    repeat (300) send_random(CMD_ADD);
  endtask

  task automatic test_random_mul();
    repeat (300) send_random(CMD_MUL);
  endtask

  task automatic test_random_mixed();
    repeat (400) send_random(logic'($urandom_range(0, 1)));
  endtask

  // full rate on both sides
  task automatic test_back_to_back();
    idle_en = 1'b0;
    repeat (200) send_random(logic'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------- result side

  initial begin : result_monitor
    fraction_t   want;
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (reduced_pending.size() == 0) begin
          $error("result item with nothing pending");
          fail_count++;
        end else begin
          want = reduced_pending.pop_front();
          if (m_axis_tdata[NUM_OUT_W-1:0] !== want.num) begin
            $error("num_out: expected %0d, got %0d", $signed(want.num),
                   $signed(m_axis_tdata[NUM_OUT_W-1:0]));
            fail_count++;
          end
          if (m_axis_tdata[NUM_OUT_W +: DEN_OUT_W] !== want.den) begin
            $error("den_out: expected %0d, got %0d", $signed(want.den),
                   $signed(m_axis_tdata[NUM_OUT_W +: DEN_OUT_W]));
            fail_count++;
          end
          if (m_axis_tuser !== want.div_zero) begin
            $error("div_zero: expected %0b, got %0b", want.div_zero, m_axis_tuser);
            fail_count++;
          end
        end
      end
      // receiver stalls in bursts
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : run_tests
    int unsigned drain;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_operand_extremes();
    test_special_cases();
    test_random_add();
    test_random_mul();
    test_random_mixed();
    test_back_to_back();
    s_axis_tvalid <= 1'b0;
    while (reduced_pending.size() != 0) @(posedge clk);
    // longest euclid chain plus the two divisions, so a stray extra item shows up
    drain = 2000;
    repeat (drain) @(posedge clk);
    if (fail_count == 0) begin
      $display("fraction_add_mul_reduce verification clean");
    end else begin
      $display("fraction_add_mul_reduce verification failed");
    end
    $finish;
  end

  // watchdog, several times the slowest correct run
  initial begin : watchdog
    #100ms;
    $display("fraction_add_mul_reduce verification failed");
    $finish;
  end

endmodule
